/* hw/rtl/sparse_set_component_table_macros.svh */
// Assertion macros for the sparse set component table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SPARSE_SET_COMPONENT_TABLE_MACROS_SVH
`define SPARSE_SET_COMPONENT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSCT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssct assertion failed");
// next-cycle implication
`define SSCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssct assertion failed");
`else
`define SSCT_ASSERT_IMP(label, ante, cons)
`define SSCT_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* hw/rtl/ssct_pkg.sv */
// Shared constants, codes and types of the sparse set component table.
// No dependencies.
package ssct_pkg;

    localparam int MAP_DEPTH   = 1024;
    localparam int DENSE_DEPTH = 1024;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);
    localparam int DENSE_AW    = $clog2(DENSE_DEPTH);
    localparam int CNT_W       = $clog2(DENSE_DEPTH + 1);
    localparam int INDEX_W     = 10;
    localparam int GEN_W       = 32;
    localparam int COMP_W      = 64;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_POS    = 3'd4;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [GEN_W-1:0]   gen;
        logic [COMP_W-1:0]  comp;
    } dense_word_t;

    localparam int DENSE_W = $bits(dense_word_t);

    typedef struct packed {
        logic                map_we;
        logic [MAP_AW-1:0]   map_waddr;
        logic [DENSE_AW-1:0] map_wdata;
        logic [MAP_AW-1:0]   map_raddr;
        logic                dense_we;
        logic [DENSE_AW-1:0] dense_waddr;
        dense_word_t         dense_wdata;
        logic [DENSE_AW-1:0] dense_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                present;
        logic [COMP_W-1:0]   comp;
        logic [INDEX_W-1:0]  fidx;
        logic [GEN_W-1:0]    fgen;
        logic [DENSE_AW-1:0] epos;
        logic [CNT_W-1:0]    count;
    } res_t;

endpackage

/* hw/rtl/sparse_set_component_table.sv */
// Top level of the sparse set component table: memories, sequencer, result register.
// Depends on ssct_pkg, ssct_ram, ssct_seq and the assertion macro header.
//
// Usage:
//   Command channel: drive mode and the operand ports with start high; the
//   transaction is taken at a clock edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status, present,
//   component_out, found_index, found_generation, entry_position and
//   entry_count. The receiver cannot stall; each command gives one result.
//   Insert, remove and lookup go through the map read state and then the dense
//   read state before the result is registered; read at position, clear and
//   unused modes register it after the map read state alone. The result is
//   taken at the edge that ends the done cycle, and the next command can be
//   accepted at that same edge. The pace is set by the map read followed by the
//   dependent dense read (the last entry is fetched alongside the map read).
//   Reset: the entry count goes to zero and the position map is swept to zero,
//   one entry a cycle, while busy stays high.
`include "sparse_set_component_table_macros.svh"

module sparse_set_component_table import ssct_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [INDEX_W-1:0]  handle_index,
    input  logic [GEN_W-1:0]    handle_generation,
    input  logic [COMP_W-1:0]   component_in,
    input  logic [DENSE_AW-1:0] read_position,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic                present,
    output logic [COMP_W-1:0]   component_out,
    output logic [INDEX_W-1:0]  found_index,
    output logic [GEN_W-1:0]    found_generation,
    output logic [DENSE_AW-1:0] entry_position,
    output logic [CNT_W-1:0]    entry_count
);

    mem_req_t            mem;
    logic [DENSE_AW-1:0] map_rdata;
    dense_word_t         dense_rdata;
    logic                res_valid;
    res_t                res;
    logic                done_reg;
    res_t                res_reg;

    ssct_ram #(
        .WIDTH (DENSE_AW),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (mem.map_we),
        .waddr (mem.map_waddr),
        .wdata (mem.map_wdata),
        .raddr (mem.map_raddr),
        .rdata (map_rdata)
    );

    ssct_ram #(
        .WIDTH (DENSE_W),
        .DEPTH (DENSE_DEPTH)
    ) u_dense (
        .clk   (clk),
        .we    (mem.dense_we),
        .waddr (mem.dense_waddr),
        .wdata (mem.dense_wdata),
        .raddr (mem.dense_raddr),
        .rdata (dense_rdata)
    );

    ssct_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .mode              (mode),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .component_in      (component_in),
        .read_position     (read_position),
        .busy              (busy),
        .map_rdata         (map_rdata),
        .dense_rdata       (dense_rdata),
        .mem               (mem),
        .res_valid         (res_valid),
        .res               (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign done             = done_reg;
    assign status           = res_reg.status;
    assign present          = res_reg.present;
    assign component_out    = res_reg.comp;
    assign found_index      = res_reg.fidx;
    assign found_generation = res_reg.fgen;
    assign entry_position   = res_reg.epos;
    assign entry_count      = res_reg.count;

    `SSCT_ASSERT_IMP(a_done_idle, done, !busy)
    `SSCT_ASSERT_NXT(a_done_single, done, !done)
    `SSCT_ASSERT_IMP(a_full_count, done && (status == STATUS_FULL), entry_count == CNT_W'(DENSE_DEPTH))
    `SSCT_ASSERT_IMP(a_present_ok, done && present, status == STATUS_OK)

endmodule

/* hw/rtl/ssct_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ssct_seq.sv */
// Operation sequencer: issues map and dense reads, checks the handle, writes back.
// Depends on ssct_pkg.
module ssct_seq import ssct_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MODE_W-1:0]   mode,
    input  logic [INDEX_W-1:0]  handle_index,
    input  logic [GEN_W-1:0]    handle_generation,
    input  logic [COMP_W-1:0]   component_in,
    input  logic [DENSE_AW-1:0] read_position,
    output logic                busy,
    input  logic [DENSE_AW-1:0] map_rdata,
    input  dense_word_t         dense_rdata,
    output mem_req_t            mem,
    output logic                res_valid,
    output res_t                res
);

    localparam logic [1:0] ST_CLR   = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MAP   = 2'd2;
    localparam logic [1:0] ST_DENSE = 2'd3;

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DENSE_DEPTH);
    localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_DEPTH - 1);

    logic [1:0]          state_reg, state_next;
    logic [MAP_AW-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [GEN_W-1:0]    gen_reg;
    logic [COMP_W-1:0]   comp_reg;
    logic [DENSE_AW-1:0] rpos_reg;
    dense_word_t         last_reg;
    logic [DENSE_AW-1:0] pos_reg;
    logic                pos_ok_reg;

    logic accept;
    logic idx_ok;
    logic rd_ok;
    logic hit;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign idx_ok = (32'(idx_reg) < 32'(MAP_DEPTH));
    assign rd_ok  = (CNT_W'(rpos_reg) < count_reg);
    // pos_ok gates the compare, so stale dense contents never leak into hit
    assign hit    = pos_ok_reg && (dense_rdata.idx == idx_reg)
                    && (dense_rdata.gen == gen_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;

        mem             = '0;
        mem.map_raddr   = MAP_AW'(handle_index);
        mem.dense_raddr = (mode == MODE_READ) ? read_position
                                              : DENSE_AW'(count_reg - 1'b1);
        res_valid = 1'b0;
        res       = '0;
        res.count = count_reg;

        case (state_reg)
            ST_CLR:
            begin
                // map sweep after reset
                mem.map_we    = 1'b1;
                mem.map_waddr = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                mem.dense_raddr = map_rdata;
                if (mode_reg inside {MODE_INSERT, MODE_REMOVE, MODE_LOOKUP})
                begin
                    if (idx_ok)
                    begin
                        state_next = ST_DENSE;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_RANGE;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    case (mode_reg)
                        MODE_READ:
                        begin
                            if (rd_ok)
                            begin
                                res.comp = dense_rdata.comp;
                                res.fidx = dense_rdata.idx;
                                res.fgen = dense_rdata.gen;
                                res.epos = rpos_reg;
                            end
                            else
                            begin
                                res.status = STATUS_POS;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            res.count  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DENSE:
            begin
                res_valid   = 1'b1;
                res.present = hit;
                state_next  = ST_IDLE;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (hit)
                        begin
                            mem.dense_we    = 1'b1;
                            mem.dense_waddr = pos_reg;
                            mem.dense_wdata = '{idx: idx_reg, gen: gen_reg, comp: comp_reg};
                            res.epos        = pos_reg;
                        end
                        else if (count_reg == CNT_FULL)
                        begin
                            res.status = STATUS_FULL;
                        end
                        else
                        begin
                            mem.dense_we    = 1'b1;
                            mem.dense_waddr = DENSE_AW'(count_reg);
                            mem.dense_wdata = '{idx: idx_reg, gen: gen_reg, comp: comp_reg};
                            mem.map_we      = 1'b1;
                            mem.map_waddr   = MAP_AW'(idx_reg);
                            mem.map_wdata   = DENSE_AW'(count_reg);
                            count_next      = count_reg + 1'b1;
                            res.epos        = DENSE_AW'(count_reg);
                            res.count       = count_reg + 1'b1;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (hit)
                        begin
                            // last entry fills the hole; harmless when it is the hole
                            mem.dense_we    = 1'b1;
                            mem.dense_waddr = pos_reg;
                            mem.dense_wdata = last_reg;
                            mem.map_we      = 1'b1;
                            mem.map_waddr   = MAP_AW'(last_reg.idx);
                            mem.map_wdata   = pos_reg;
                            count_next      = count_reg - 1'b1;
                            res.epos        = pos_reg;
                            res.count       = count_reg - 1'b1;
                        end
                        else
                        begin
                            res.status = STATUS_ABSENT;
                        end
                    end
                    default:
                    begin
                        if (hit)
                        begin
                            res.comp = dense_rdata.comp;
                            res.epos = pos_reg;
                        end
                        else
                        begin
                            res.status = STATUS_ABSENT;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            idx_reg  <= handle_index;
            gen_reg  <= handle_generation;
            comp_reg <= component_in;
            rpos_reg <= read_position;
        end
        if (state_reg == ST_MAP)
        begin
            last_reg   <= dense_rdata;
            pos_reg    <= map_rdata;
            pos_ok_reg <= (CNT_W'(map_rdata) < count_reg);
        end
    end

endmodule
